// ===== sv/ili_pkg.sv =====
// shared types and constants for the interval list intersection block
package ili_pkg;

	localparam int MAX_RANGES = 16;
	localparam int LETTER_W   = 21;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int MODE_W     = 2;
	localparam int DATA_W     = 48;
	localparam int DATA_PAD   = DATA_W - 2 * LETTER_W;
	localparam int USER_W     = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef struct packed {
		letter_t hi;
		letter_t lo;
	} range_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		range_t           rng;
	} list_wr_t;

endpackage

// ===== sv/interval_list_intersection.sv =====
// top level of the sorted interval list intersection block
//
// input channel (s_*): one transaction per command. tuser carries the mode:
// load into list a, load into list b, or run. a load gives no result;
// mode 3 is taken and ignored. a load into a full list (16 entries)
// is dropped and raises the overflow flag.
// a run walks both lists with a two-pointer merge. every overlap gives
// one output transaction (max of starts, min of ends); the final one has
// tlast set. with no overlap at all a single transaction with the empty
// flag and tlast goes out. after the run both lists and the flag clear.
// merge: a step runs the states check, a_below, b_below, start, end and
// push, and returns to check early when a below compare advances i or j;
// the single shared magnitude comparator does all four compares of a step
// in turn, and the list read is registered. s_tready is low for the whole run.
// output channel (m_*): one output register; one overlap is held back so
// that tlast is known, and the merge waits when the register is full and
// m_tready is low. nothing is lost under stall.
// reset (arst_n low) empties both lists, clears the overflow flag and the
// output valid; list contents are not cleared.
module interval_list_intersection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ili_pkg::DATA_W-1:0]   s_tdata,   // range_start, range_end, zero pad
	input  logic [ili_pkg::MODE_W-1:0]   s_tuser,   // mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ili_pkg::DATA_W-1:0]   m_tdata,   // overlap_start, overlap_end, zero pad
	output logic [ili_pkg::USER_W-1:0]   m_tuser,   // empty_result, overflowed
	output logic                         m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_A_BELOW,
		ST_B_BELOW,
		ST_START,
		ST_END,
		ST_PUSH,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [ili_pkg::CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [ili_pkg::CNT_W-1:0] i_q, j_q;
	logic                      ovf_q;

	// held-back overlap and the one being built
	logic              pend_valid_q;
	ili_pkg::range_t   pend_q;
	ili_pkg::range_t   cur_q;

	// output register
	logic              out_valid_q;
	ili_pkg::range_t   out_rng_q;
	logic              out_empty_q;
	logic              out_ovf_q;
	logic              out_last_q;

	ili_pkg::list_wr_t wr_a, wr_b;
	ili_pkg::range_t   rd_a, rd_b;
	ili_pkg::range_t   in_rng;
	logic              in_fire;
	logic              out_free;
	logic              out_load;

	// shared comparator
	ili_pkg::letter_t  cmp_x, cmp_y;
	logic              cmp_lt;

	assign in_rng.lo = s_tdata[ili_pkg::LETTER_W-1:0];
	assign in_rng.hi = s_tdata[2*ili_pkg::LETTER_W-1:ili_pkg::LETTER_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	// output register takes a new transaction this cycle
	assign out_load  = out_free &&
		(((state_q == ST_PUSH) && pend_valid_q) || (state_q == ST_FINISH));

	// list writes happen only on accepted loads with room left
	always_comb begin
		wr_a.en   = in_fire && (s_tuser == ili_pkg::MODE_LOAD_A) &&
			(cnt_a_q < ili_pkg::CNT_W'(ili_pkg::MAX_RANGES));
		wr_a.addr = cnt_a_q[ili_pkg::IDX_W-1:0];
		wr_a.rng  = in_rng;
		wr_b.en   = in_fire && (s_tuser == ili_pkg::MODE_LOAD_B) &&
			(cnt_b_q < ili_pkg::CNT_W'(ili_pkg::MAX_RANGES));
		wr_b.addr = cnt_b_q[ili_pkg::IDX_W-1:0];
		wr_b.rng  = in_rng;
	end

	ili_list u_list_a (
		.clk     (clk),
		.wr      (wr_a),
		.rd_addr (i_q[ili_pkg::IDX_W-1:0]),
		.rd_data (rd_a)
	);

	ili_list u_list_b (
		.clk     (clk),
		.wr      (wr_b),
		.rd_addr (j_q[ili_pkg::IDX_W-1:0]),
		.rd_data (rd_b)
	);

	// operand select per merge phase
	always_comb begin
		unique case (state_q)
			ST_A_BELOW: begin
				cmp_x = rd_a.hi;
				cmp_y = rd_b.lo;
			end
			ST_B_BELOW: begin
				cmp_x = rd_b.hi;
				cmp_y = rd_a.lo;
			end
			ST_START: begin
				cmp_x = rd_b.lo;
				cmp_y = rd_a.lo;
			end
			ST_END: begin
				cmp_x = rd_a.hi;
				cmp_y = rd_b.hi;
			end
			default: begin
				cmp_x = rd_a.hi;
				cmp_y = rd_b.hi;
			end
		endcase
	end

	assign cmp_lt = cmp_x < cmp_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						priority case (s_tuser)
							ili_pkg::MODE_LOAD_A: begin
								if (wr_a.en) cnt_a_q <= cnt_a_q + 1'b1;
								else ovf_q <= 1'b1;
							end
							ili_pkg::MODE_LOAD_B: begin
								if (wr_b.en) cnt_b_q <= cnt_b_q + 1'b1;
								else ovf_q <= 1'b1;
							end
							ili_pkg::MODE_RUN: begin
								pend_valid_q <= 1'b0;
								state_q      <= ST_CHECK;
							end
							default: begin
							end
						endcase
					end
				end
				// list read data for i and j is ready after this cycle
				ST_CHECK: begin
					if ((i_q < cnt_a_q) && (j_q < cnt_b_q)) state_q <= ST_A_BELOW;
					else state_q <= ST_FINISH;
				end
				ST_A_BELOW: begin
					if (cmp_lt) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_B_BELOW;
					end
				end
				ST_B_BELOW: begin
					if (cmp_lt) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					cur_q.lo <= cmp_lt ? rd_a.lo : rd_b.lo;
					state_q  <= ST_END;
				end
				// a tie advances list b
				ST_END: begin
					if (cmp_lt) begin
						cur_q.hi <= rd_a.hi;
						i_q      <= i_q + 1'b1;
					end else begin
						cur_q.hi <= rd_b.hi;
						j_q      <= j_q + 1'b1;
					end
					state_q <= ST_PUSH;
				end
				// send the held overlap if there is one, keep the new one back
				ST_PUSH: begin
					if (!pend_valid_q) begin
						pend_q       <= cur_q;
						pend_valid_q <= 1'b1;
						state_q      <= ST_CHECK;
					end else if (out_free) begin
						out_rng_q   <= pend_q;
						out_empty_q <= 1'b0;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b0;
						pend_q      <= cur_q;
						state_q     <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_rng_q   <= pend_valid_q ? pend_q : '0;
						out_empty_q <= !pend_valid_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b1;
						pend_valid_q <= 1'b0;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						i_q         <= '0;
						j_q         <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{ili_pkg::DATA_PAD{1'b0}}, out_rng_q.hi, out_rng_q.lo};
	assign m_tuser  = {out_ovf_q, out_empty_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/ili_list.sv =====
// range list storage with one write port and one registered read port
module ili_list (
	input  logic                    clk,
	input  ili_pkg::list_wr_t       wr,
	input  logic [ili_pkg::IDX_W-1:0] rd_addr,
	output ili_pkg::range_t         rd_data
);

	ili_pkg::range_t mem_q [ili_pkg::MAX_RANGES];
	ili_pkg::range_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.rng;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
